/* hw/rtl/fds_pkg.sv */
// ----------------------------------------------------------------------------
// fds_pkg
// Widths, pipeline depths and register indexes shared by the dielectric
// sampler and its square-root and divider pipelines.
// ----------------------------------------------------------------------------
package fds_pkg;

    // port widths
    localparam int DirW   = 16;
    localparam int RandW  = 16;
    localparam int IdxW   = 16;
    localparam int RsqW   = 20;
    localparam int DataW  = 32;
    localparam int AddrW  = 4;
    localparam int RegIdxW = AddrW - 2;

    // register indexes
    localparam logic [RegIdxW-1:0] RegIncident    = 2'd0;
    localparam logic [RegIdxW-1:0] RegTransmitted = 2'd1;
    localparam logic [RegIdxW-1:0] RegRatio       = 2'd2;
    localparam logic [RegIdxW-1:0] RegRatioSq     = 2'd3;

    // datapath widths
    localparam int DpW     = 2 * DirW;        // I_k * N_k
    localparam int DotW    = DpW + 2;         // I.N
    localparam int CosW    = DotW + 1 - 14;   // cos_i, Q.14
    localparam int CcW     = 2 * CosW;        // cos_i squared
    localparam int RivW    = IdxW + 1 + DirW; // ratio * I_k
    localparam int RcosW   = IdxW + 1 + CosW; // ratio * cos_i
    localparam int DnW     = DotW + DirW;     // dot * N_k
    localparam int RflSumW = DnW + 2;
    localparam int RflW    = RflSumW - 28;    // rounded reflection component
    localparam int SinW    = 29;              // sin2_i, Q.28 up to 1.0
    localparam int S2tW    = RsqW + SinW;     // sin2_t, Q.42
    localparam int Q42W    = 43;
    localparam int PW      = IdxW + 1 + CosW; // n * cos products
    localparam int CoefW   = PW + 1;
    localparam int CnW     = CoefW + DirW;
    localparam int RfrSumW = CnW + 2;
    localparam int RfrW    = RfrSumW - 27;    // rounded refraction component
    localparam int SqW     = 35;              // clamped quotient squared

    // square root pipeline
    localparam int SqrtInW      = Q42W - 14;
    localparam int SqrtOutW     = 15;
    localparam int SqrtIters    = SqrtOutW;
    localparam int SqrtPerStage = 3;
    localparam int SqrtStages   = SqrtIters / SqrtPerStage;
    localparam int SqrtWorkW    = SqrtInW + 1;
    localparam int SqrtTopShift = 2 * (SqrtIters - 1);

    // divider pipeline
    localparam int DivW        = PW + 1;
    localparam int FracW       = 16;
    localparam int QuoW        = 18;
    localparam int RemW        = DivW + QuoW;
    localparam int DivPerStage = 2;
    localparam int DivStages   = QuoW / DivPerStage;

    // total pipeline depth
    localparam int NumStages = 6 + SqrtStages + 2 + DivStages + 2;

endpackage

/* hw/rtl/fds_isqrt.sv */
// ----------------------------------------------------------------------------
// fds_isqrt
// Pipelined integer square root, three result bits per stage.
// ----------------------------------------------------------------------------
module fds_isqrt import fds_pkg::*; (
    input  logic                aclk,
    input  logic                en,
    input  logic [SqrtInW-1:0]  rad,
    output logic [SqrtOutW-1:0] root
);

    logic [SqrtWorkW-1:0] v_reg [SqrtStages-1];
    logic [SqrtWorkW-1:0] r_reg [SqrtStages];

    for (genvar j = 0; j < SqrtStages; j++) begin : g_stage
        logic [SqrtWorkW-1:0] v_in, r_in, v_next, r_next, bitv;

        if (j == 0) begin : g_head
            assign v_in = SqrtWorkW'(rad);
            assign r_in = '0;
        end else begin : g_tail
            assign v_in = v_reg[j-1];
            assign r_in = r_reg[j-1];
        end

        // restoring square root steps
        always_comb begin
            v_next = v_in;
            r_next = r_in;
            bitv   = '0;
            for (int k = 0; k < SqrtPerStage; k++) begin
                bitv = SqrtWorkW'(1) << (SqrtTopShift - 2 * (j * SqrtPerStage + k));
                if (v_next >= r_next + bitv) begin
                    v_next = v_next - (r_next + bitv);
                    r_next = (r_next >> 1) + bitv;
                end else begin
                    r_next = r_next >> 1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[j] <= r_next;
            end
        end

        if (j < SqrtStages - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (en) begin
                    v_reg[j] <= v_next;
                end
            end
        end
    end

    assign root = r_reg[SqrtStages-1][SqrtOutW-1:0];

endmodule

/* hw/rtl/fds_div.sv */
// ----------------------------------------------------------------------------
// fds_div
// Pipelined restoring divider: floor(num * 2^16 / den), two bits per stage.
// ----------------------------------------------------------------------------
module fds_div import fds_pkg::*; (
    input  logic            aclk,
    input  logic            en,
    input  logic [DivW-1:0] num_mag,
    input  logic [DivW-1:0] den_mag,
    output logic [QuoW-1:0] quo
);

    logic [RemW-1:0] rem_reg [DivStages-1];
    logic [DivW-1:0] den_reg [DivStages-1];
    logic [QuoW-1:0] quo_reg [DivStages];

    for (genvar j = 0; j < DivStages; j++) begin : g_stage
        logic [RemW-1:0] rem_in, rem_next, trial;
        logic [DivW-1:0] den_in;
        logic [QuoW-1:0] quo_in, quo_next;

        if (j == 0) begin : g_head
            assign rem_in = RemW'(num_mag) << FracW;
            assign den_in = den_mag;
            assign quo_in = '0;
        end else begin : g_tail
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        // compare and subtract, quotient bits shift in from the right
        always_comb begin
            rem_next = rem_in;
            quo_next = quo_in;
            trial    = '0;
            for (int k = 0; k < DivPerStage; k++) begin
                trial = RemW'(den_in) << (QuoW - 1 - (j * DivPerStage + k));
                if (rem_next >= trial) begin
                    rem_next = rem_next - trial;
                    quo_next = {quo_next[QuoW-2:0], 1'b1};
                end else begin
                    quo_next = {quo_next[QuoW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[j] <= quo_next;
            end
        end

        if (j < DivStages - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= rem_next;
                    den_reg[j] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[DivStages-1];

endmodule

/* hw/rtl/fresnel_dielectric_sample_top.sv */
// ----------------------------------------------------------------------------
// fresnel_dielectric_sample_top
// Samples a smooth dielectric surface: mirror or refracted direction chosen
// by total internal reflection, a zero Fresnel denominator, or by comparing
// a random number with the Fresnel reflectance.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item is an incoming direction, a normal (Q2.14) and a
//   Q0.16 random number. m_ channel: one result item per input item, with
//   the outgoing direction, a refraction flag and a total internal
//   reflection flag, in input order.
//   APB port: four index registers at byte addresses 0, 4, 8, 12; write
//   them only while no item is in flight.
//   Stages from acceptance to m_valid: six front stages, five square-root
//   stages of three root bits, two Fresnel stages, nine divider stages of
//   two quotient bits, a squaring stage and the output register.
//   Throughput is one item per cycle while the output is not stalled.
//   When m_ready is low with a result waiting, the whole pipeline holds and
//   s_ready drops; no item is lost or repeated. Items keep flowing into
//   empty slots whenever the output is free or being taken.
//   Reset empties the pipeline and loads indices of 1.0 (ratio 1.0).
// ----------------------------------------------------------------------------
module fresnel_dielectric_sample_top import fds_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [DirW-1:0]  s_in_dir_x,
    input  logic signed [DirW-1:0]  s_in_dir_y,
    input  logic signed [DirW-1:0]  s_in_dir_z,
    input  logic signed [DirW-1:0]  s_norm_x,
    input  logic signed [DirW-1:0]  s_norm_y,
    input  logic signed [DirW-1:0]  s_norm_z,
    input  logic [RandW-1:0]        s_uniform_rand,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_took_transmission,
    output logic                    m_total_internal,
    output logic signed [DirW-1:0]  m_out_dir_x,
    output logic signed [DirW-1:0]  m_out_dir_y,
    output logic signed [DirW-1:0]  m_out_dir_z,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [AddrW-1:0]        paddr,
    input  logic [DataW-1:0]        pwdata,
    output logic [DataW-1:0]        prdata,
    output logic                    pready
);

    typedef struct packed {
        logic                       tir;
        logic [RandW-1:0]           u;
        logic signed [CosW-1:0]     cos_i;
        logic signed [RcosW-1:0]    rcos;
        logic [2:0][RivW-1:0]       riv;
        logic [2:0][DirW-1:0]       nv;
        logic [2:0][RflW-1:0]       rf;
    } mid_t;

    typedef struct packed {
        logic                       tir;
        logic                       den_zero;
        logic                       clamp_par;
        logic                       clamp_perp;
        logic [RandW-1:0]           u;
        logic [2:0][RflW-1:0]       rf;
        logic [2:0][RfrW-1:0]       tr;
    } side_t;

    localparam logic signed [CcW-1:0]     OneQ28   = CcW'(1) <<< 28;
    localparam logic [S2tW-1:0]           OneQ42   = S2tW'(1) << 42;
    localparam logic signed [DotW:0]      CosHalf  = (DotW + 1)'(8192);
    localparam logic signed [RflSumW-1:0] RflHalf  = RflSumW'(1) <<< 27;
    localparam logic signed [RfrSumW-1:0] RfrHalf  = RfrSumW'(1) <<< 26;
    localparam logic [QuoW-1:0]           ClampQ   = QuoW'(1) << 17;
    localparam logic signed [RfrW-1:0]    SatHi    = RfrW'(32767);
    localparam logic signed [RfrW-1:0]    SatLo    = -RfrW'(32768);

    function automatic logic [DivW-1:0] mag(input logic signed [DivW-1:0] x);
        mag = x[DivW-1] ? DivW'(-x) : DivW'(x);
    endfunction

    function automatic logic [DirW-1:0] sat_dir(input logic signed [RfrW-1:0] x);
        if (x > SatHi) begin
            sat_dir = SatHi[DirW-1:0];
        end else if (x < SatLo) begin
            sat_dir = SatLo[DirW-1:0];
        end else begin
            sat_dir = x[DirW-1:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [IdxW-1:0] idx_inc_reg, idx_trn_reg, ratio_reg;
    logic [RsqW-1:0] ratio_sq_reg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_inc_reg  <= IdxW'(8192);
            idx_trn_reg  <= IdxW'(8192);
            ratio_reg    <= IdxW'(8192);
            ratio_sq_reg <= RsqW'(16384);
        end else if (cfg_wr) begin
            case (paddr[AddrW-1:2])
                RegIncident:    idx_inc_reg  <= pwdata[IdxW-1:0];
                RegTransmitted: idx_trn_reg  <= pwdata[IdxW-1:0];
                RegRatio:       ratio_reg    <= pwdata[IdxW-1:0];
                RegRatioSq:     ratio_sq_reg <= pwdata[RsqW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[AddrW-1:2])
            RegIncident:    prdata = DataW'(idx_inc_reg);
            RegTransmitted: prdata = DataW'(idx_trn_reg);
            RegRatio:       prdata = DataW'(ratio_reg);
            RegRatioSq:     prdata = DataW'(ratio_sq_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control: the whole pipe moves unless the output is stuck
    // ------------------------------------------------------------------
    logic [NumStages-1:0] vld_reg;
    logic                 en;

    assign en      = !vld_reg[NumStages-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[NumStages-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NumStages-2:0], s_valid};
        end
    end

    logic signed [DirW-1:0] in_iv [3];
    logic signed [DirW-1:0] in_nv [3];
    assign in_iv[0] = s_in_dir_x;
    assign in_iv[1] = s_in_dir_y;
    assign in_iv[2] = s_in_dir_z;
    assign in_nv[0] = s_norm_x;
    assign in_nv[1] = s_norm_y;
    assign in_nv[2] = s_norm_z;

    // ------------------------------------------------------------------
    // stage A: component products of I.N
    // ------------------------------------------------------------------
    logic signed [DirW-1:0] a_iv_reg [3];
    logic signed [DirW-1:0] a_nv_reg [3];
    logic signed [DpW-1:0]  a_dp_reg [3];
    logic [RandW-1:0]       a_u_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                a_iv_reg[k] <= in_iv[k];
                a_nv_reg[k] <= in_nv[k];
                a_dp_reg[k] <= in_iv[k] * in_nv[k];
            end
            a_u_reg <= s_uniform_rand;
        end
    end

    // ------------------------------------------------------------------
    // stage B: dot product, rounded cos_i, ratio * I
    // ------------------------------------------------------------------
    logic signed [DotW-1:0] b_dot_next, b_dot_reg;
    logic signed [DotW:0]   b_neg;
    logic signed [CosW-1:0] b_cos_reg;
    logic signed [DirW-1:0] b_iv_reg [3];
    logic signed [DirW-1:0] b_nv_reg [3];
    logic signed [RivW-1:0] b_riv_reg [3];
    logic [RandW-1:0]       b_u_reg;
    logic signed [IdxW:0]   ratio_s;

    assign ratio_s    = $signed({1'b0, ratio_reg});
    assign b_dot_next = DotW'(a_dp_reg[0]) + DotW'(a_dp_reg[1]) + DotW'(a_dp_reg[2]);
    assign b_neg      = CosHalf - (DotW + 1)'(b_dot_next);

    always_ff @(posedge aclk) begin
        if (en) begin
            b_dot_reg <= b_dot_next;
            b_cos_reg <= b_neg[DotW:14];
            for (int k = 0; k < 3; k++) begin
                b_iv_reg[k]  <= a_iv_reg[k];
                b_nv_reg[k]  <= a_nv_reg[k];
                b_riv_reg[k] <= ratio_s * a_iv_reg[k];
            end
            b_u_reg <= a_u_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage C: cos_i squared, dot * N, ratio * cos_i
    // ------------------------------------------------------------------
    logic signed [CcW-1:0]   c_cc_reg;
    logic signed [DnW-1:0]   c_dn_reg [3];
    logic signed [RcosW-1:0] c_rcos_reg;
    logic signed [CosW-1:0]  c_cos_reg;
    logic signed [DirW-1:0]  c_iv_reg [3];
    logic signed [DirW-1:0]  c_nv_reg [3];
    logic signed [RivW-1:0]  c_riv_reg [3];
    logic [RandW-1:0]        c_u_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            c_cc_reg   <= b_cos_reg * b_cos_reg;
            c_rcos_reg <= ratio_s * b_cos_reg;
            c_cos_reg  <= b_cos_reg;
            for (int k = 0; k < 3; k++) begin
                c_dn_reg[k]  <= b_dot_reg * b_nv_reg[k];
                c_iv_reg[k]  <= b_iv_reg[k];
                c_nv_reg[k]  <= b_nv_reg[k];
                c_riv_reg[k] <= b_riv_reg[k];
            end
            c_u_reg <= b_u_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage D: sin2_i and the rounded mirror direction
    // ------------------------------------------------------------------
    logic [SinW-1:0]           d_s2i_next, d_s2i_reg;
    logic signed [RflSumW-1:0] d_rsum [3];
    logic signed [RflW-1:0]    d_rf_reg [3];
    logic signed [RcosW-1:0]   d_rcos_reg;
    logic signed [CosW-1:0]    d_cos_reg;
    logic signed [DirW-1:0]    d_nv_reg [3];
    logic signed [RivW-1:0]    d_riv_reg [3];
    logic [RandW-1:0]          d_u_reg;

    always_comb begin
        if (c_cc_reg >= OneQ28) begin
            d_s2i_next = '0;
        end else begin
            d_s2i_next = SinW'(OneQ28 - c_cc_reg);
        end
        for (int k = 0; k < 3; k++) begin
            d_rsum[k] = (RflSumW'(c_iv_reg[k]) <<< 28) - (RflSumW'(c_dn_reg[k]) <<< 1)
                        + RflHalf;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_s2i_reg  <= d_s2i_next;
            d_rcos_reg <= c_rcos_reg;
            d_cos_reg  <= c_cos_reg;
            for (int k = 0; k < 3; k++) begin
                d_rf_reg[k]  <= d_rsum[k][RflSumW-1:28];
                d_nv_reg[k]  <= c_nv_reg[k];
                d_riv_reg[k] <= c_riv_reg[k];
            end
            d_u_reg <= c_u_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage E: sin2_t = ratio^2 * sin2_i
    // ------------------------------------------------------------------
    logic [S2tW-1:0]         e_s2t_reg;
    logic signed [RcosW-1:0] e_rcos_reg;
    logic signed [CosW-1:0]  e_cos_reg;
    logic signed [DirW-1:0]  e_nv_reg [3];
    logic signed [RivW-1:0]  e_riv_reg [3];
    logic signed [RflW-1:0]  e_rf_reg [3];
    logic [RandW-1:0]        e_u_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            e_s2t_reg  <= S2tW'(ratio_sq_reg) * S2tW'(d_s2i_reg);
            e_rcos_reg <= d_rcos_reg;
            e_cos_reg  <= d_cos_reg;
            for (int k = 0; k < 3; k++) begin
                e_nv_reg[k]  <= d_nv_reg[k];
                e_riv_reg[k] <= d_riv_reg[k];
                e_rf_reg[k]  <= d_rf_reg[k];
            end
            e_u_reg <= d_u_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage F: total internal reflection test, radicand for cos_t
    // ------------------------------------------------------------------
    logic [Q42W-1:0]    f_diff;
    logic [SqrtInW-1:0] f_v_reg;
    mid_t               mid_next;
    mid_t               mid_reg [SqrtStages+1];

    assign f_diff = Q42W'(OneQ42) - e_s2t_reg[Q42W-1:0];

    always_comb begin
        mid_next.tir   = e_s2t_reg >= OneQ42;
        mid_next.u     = e_u_reg;
        mid_next.cos_i = e_cos_reg;
        mid_next.rcos  = e_rcos_reg;
        for (int k = 0; k < 3; k++) begin
            mid_next.riv[k] = e_riv_reg[k];
            mid_next.nv[k]  = e_nv_reg[k];
            mid_next.rf[k]  = e_rf_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_v_reg    <= f_diff[Q42W-1:14];
            mid_reg[0] <= mid_next;
            for (int i = 1; i <= SqrtStages; i++) begin
                mid_reg[i] <= mid_reg[i-1];
            end
        end
    end

    // cos_t square root, in step with the carried fields
    logic [SqrtOutW-1:0] cos_t;

    fds_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (f_v_reg),
        .root (cos_t)
    );

    // ------------------------------------------------------------------
    // stage G: Fresnel products and refraction coefficient
    // ------------------------------------------------------------------
    mid_t                    mid_g;
    logic signed [SqrtOutW:0] cos_t_s;
    logic signed [IdxW:0]    ni_s, nt_s;
    logic signed [PW-1:0]    g_p0_reg, g_p1_reg, g_p2_reg, g_p3_reg;
    logic signed [PW-1:0]    g_p1_next, g_p3_next;
    logic signed [CoefW-1:0] g_coef_reg;
    mid_t                    g_mid_reg;

    assign mid_g     = mid_reg[SqrtStages];
    assign cos_t_s   = $signed({1'b0, cos_t});
    assign ni_s      = $signed({1'b0, idx_inc_reg});
    assign nt_s      = $signed({1'b0, idx_trn_reg});
    assign g_p1_next = ni_s * cos_t_s;
    assign g_p3_next = nt_s * cos_t_s;

    always_ff @(posedge aclk) begin
        if (en) begin
            g_p0_reg   <= nt_s * mid_g.cos_i;
            g_p1_reg   <= g_p1_next;
            g_p2_reg   <= ni_s * mid_g.cos_i;
            g_p3_reg   <= g_p3_next;
            g_coef_reg <= CoefW'(mid_g.rcos) - (CoefW'(cos_t_s) <<< 13);
            g_mid_reg  <= mid_g;
        end
    end

    // ------------------------------------------------------------------
    // stage H: numerators and denominators, coeff * N
    // ------------------------------------------------------------------
    logic signed [DivW-1:0] h_n0, h_d0, h_n1, h_d1;
    logic [DivW-1:0]        h_nm0_reg, h_dm0_reg, h_nm1_reg, h_dm1_reg;
    logic [DivW-1:0]        h_nm0, h_dm0, h_nm1, h_dm1;
    logic                   h_dz_reg, h_cl0_reg, h_cl1_reg;
    logic signed [CnW-1:0]  h_cn_reg [3];
    mid_t                   h_mid_reg;

    assign h_n0  = DivW'(g_p0_reg) - DivW'(g_p1_reg);
    assign h_d0  = DivW'(g_p0_reg) + DivW'(g_p1_reg);
    assign h_n1  = DivW'(g_p2_reg) - DivW'(g_p3_reg);
    assign h_d1  = DivW'(g_p2_reg) + DivW'(g_p3_reg);
    assign h_nm0 = mag(h_n0);
    assign h_dm0 = mag(h_d0);
    assign h_nm1 = mag(h_n1);
    assign h_dm1 = mag(h_d1);

    always_ff @(posedge aclk) begin
        if (en) begin
            h_nm0_reg <= h_nm0;
            h_dm0_reg <= h_dm0;
            h_nm1_reg <= h_nm1;
            h_dm1_reg <= h_dm1;
            h_dz_reg  <= (h_dm0 == '0) || (h_dm1 == '0);
            // a quotient of 4.0 or more is clamped anyway
            h_cl0_reg <= {2'b00, h_nm0} >= {h_dm0, 2'b00};
            h_cl1_reg <= {2'b00, h_nm1} >= {h_dm1, 2'b00};
            for (int k = 0; k < 3; k++) begin
                h_cn_reg[k] <= g_coef_reg * $signed(g_mid_reg.nv[k]);
            end
            h_mid_reg <= g_mid_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage I and divider: Fresnel quotients, rounded refraction
    // ------------------------------------------------------------------
    logic [QuoW-1:0]           quo_par, quo_perp;
    logic signed [RfrSumW-1:0] i_tsum [3];
    side_t                     side_next;
    side_t                     side_reg [DivStages];

    fds_div u_div_par (
        .aclk    (aclk),
        .en      (en),
        .num_mag (h_nm0_reg),
        .den_mag (h_dm0_reg),
        .quo     (quo_par)
    );

    fds_div u_div_perp (
        .aclk    (aclk),
        .en      (en),
        .num_mag (h_nm1_reg),
        .den_mag (h_dm1_reg),
        .quo     (quo_perp)
    );

    always_comb begin
        side_next.tir        = h_mid_reg.tir;
        side_next.den_zero   = h_dz_reg;
        side_next.clamp_par  = h_cl0_reg;
        side_next.clamp_perp = h_cl1_reg;
        side_next.u          = h_mid_reg.u;
        for (int k = 0; k < 3; k++) begin
            i_tsum[k] = (RfrSumW'($signed(h_mid_reg.riv[k])) <<< 14)
                        + RfrSumW'(h_cn_reg[k]) + RfrHalf;
            side_next.rf[k] = h_mid_reg.rf[k];
            side_next.tr[k] = i_tsum[k][RfrSumW-1:27];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < DivStages; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage J: clamp and square the two terms
    // ------------------------------------------------------------------
    logic [QuoW-1:0] j_q0, j_q1;
    logic [SqW-1:0]  j_par2_reg, j_perp2_reg;
    side_t           j_side_reg;

    assign j_q0 = (side_reg[DivStages-1].clamp_par || quo_par > ClampQ) ? ClampQ : quo_par;
    assign j_q1 = (side_reg[DivStages-1].clamp_perp || quo_perp > ClampQ) ? ClampQ : quo_perp;

    always_ff @(posedge aclk) begin
        if (en) begin
            j_par2_reg  <= SqW'(j_q0) * SqW'(j_q0);
            j_perp2_reg <= SqW'(j_q1) * SqW'(j_q1);
            j_side_reg  <= side_reg[DivStages-1];
        end
    end

    // ------------------------------------------------------------------
    // stage K: reflect or refract, saturate, output register
    // ------------------------------------------------------------------
    logic [SqW:0]           k_sum;
    logic [SqW-1:0]         k_refl;
    logic                   k_reflect;
    logic                   took_reg, tir_reg;
    logic signed [DirW-1:0] out_dir_reg [3];
    logic [DirW-1:0]        out_dir_next [3];

    assign k_sum  = (SqW + 1)'(j_par2_reg) + (SqW + 1)'(j_perp2_reg);
    assign k_refl = k_sum[SqW:1];

    always_comb begin
        k_reflect = j_side_reg.tir || j_side_reg.den_zero
                    || ((SqW'(j_side_reg.u) << 16) < k_refl);
        for (int k = 0; k < 3; k++) begin
            if (k_reflect) begin
                out_dir_next[k] = sat_dir(RfrW'($signed(j_side_reg.rf[k])));
            end else begin
                out_dir_next[k] = sat_dir($signed(j_side_reg.tr[k]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            took_reg <= !k_reflect;
            tir_reg  <= j_side_reg.tir;
            for (int k = 0; k < 3; k++) begin
                out_dir_reg[k] <= $signed(out_dir_next[k]);
            end
        end
    end

    assign m_took_transmission = took_reg;
    assign m_total_internal    = tir_reg;
    assign m_out_dir_x         = out_dir_reg[0];
    assign m_out_dir_y         = out_dir_reg[1];
    assign m_out_dir_z         = out_dir_reg[2];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(vld_reg))
        else $error("pipeline valids moved during a stall");

    a_tir_reflects: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_total_internal |-> !m_took_transmission)
        else $error("total internal reflection reported with refraction");

    a_tir_carried: assert property (@(posedge aclk) disable iff (!aresetn)
        en && vld_reg[NumStages-2] |=> m_total_internal == $past(j_side_reg.tir))
        else $error("total internal reflection flag lost in final stage");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dielectric sampler: a bit-exact predictor of
// the mirror / refraction choice runs beside the pipeline, results are
// matched in order, and the index registers are swept across several phases
// with different sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;
    import fds_pkg::*;

    localparam int LatencyWait = 40;
    localparam int CycleLimit  = 400000;
    localparam int ItemsPerPhase = 80;

    typedef struct packed {
        logic signed [DirW-1:0] ix, iy, iz;
        logic signed [DirW-1:0] nx, ny, nz;
        logic [RandW-1:0]       u;
    } ray_t;

    typedef struct packed {
        logic                   trans;
        logic                   tir;
        logic signed [DirW-1:0] ox, oy, oz;
    } bounce_t;

    typedef struct packed {
        ray_t    ray;
        logic    typed;
        bounce_t want;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [DirW-1:0] s_in_dir_x = '0, s_in_dir_y = '0, s_in_dir_z = '0;
    logic signed [DirW-1:0] s_norm_x = '0, s_norm_y = '0, s_norm_z = '0;
    logic [RandW-1:0] s_uniform_rand = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_took_transmission, m_total_internal;
    logic signed [DirW-1:0] m_out_dir_x, m_out_dir_y, m_out_dir_z;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [DataW-1:0] pwdata = '0;
    logic [DataW-1:0] prdata;
    logic pready;

    fresnel_dielectric_sample_top dut (.*);

    // local copy of the index registers
    logic [IdxW-1:0] n_inc = 16'd8192, n_trn = 16'd8192, n_rat = 16'd8192;
    logic [RsqW-1:0] n_rsq = 20'd16384;

    bounce_t pending_bounces[$];
    int errors = 0;
    int accepted = 0;
    int checked = 0;
    int tir_seen = 0;
    int trans_seen = 0;
    int send_idle = 0;
    int recv_stall = 0;
    longint cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [DirW-1:0] round_sat(longint x, int s);
        longint r;
        r = (x + (64'sd1 <<< (s - 1))) >>> s;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[DirW-1:0];
    endfunction

    // squared clamped fresnel term; returns 0 on a zero denominator
    function automatic bit fresnel_sq(longint num, longint den,
                                      output longint unsigned sq);
        longint unsigned q, mn, md;
        sq = 0;
        if (den == 0) return 1'b0;
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        q = (mn * 65536) / md;
        if (q > (64'd1 << 17)) q = 64'd1 << 17;
        sq = q * q;
        return 1'b1;
    endfunction

    function automatic bounce_t scatter_ray(ray_t r);
        longint iv[3], nv[3];
        longint dot, cos_i, cc, sin2_i, sin2_t, cos_t, coeff;
        longint ni, nt, ratio, p0, p1, p2, p3;
        longint unsigned par2, perp2, refl, uu;
        bit reflect;
        bounce_t b;
        longint o[3];
        iv[0] = r.ix; iv[1] = r.iy; iv[2] = r.iz;
        nv[0] = r.nx; nv[1] = r.ny; nv[2] = r.nz;
        ni = n_inc; nt = n_trn; ratio = n_rat;
        dot = iv[0] * nv[0] + iv[1] * nv[1] + iv[2] * nv[2];
        cos_i = (-dot + 8192) >>> 14;
        cc = cos_i * cos_i;
        sin2_i = (cc >= (64'sd1 <<< 28)) ? 0 : (64'sd1 <<< 28) - cc;
        sin2_t = longint'(n_rsq) * sin2_i;
        reflect = 1'b0;
        b = '0;
        if (sin2_t >= (64'sd1 <<< 42)) begin
            b.tir = 1'b1;
            reflect = 1'b1;
        end else begin
            cos_t = int_sqrt(longint'((64'sd1 <<< 42) - sin2_t) >> 14);
            p0 = nt * cos_i;
            p1 = ni * cos_t;
            p2 = ni * cos_i;
            p3 = nt * cos_t;
            if (!fresnel_sq(p0 - p1, p0 + p1, par2) ||
                !fresnel_sq(p2 - p3, p2 + p3, perp2)) begin
                reflect = 1'b1;
            end else begin
                refl = (par2 + perp2) >> 1;
                uu = longint'(r.u) << 16;
                if (uu < refl) reflect = 1'b1;
            end
            if (!reflect) begin
                b.trans = 1'b1;
                coeff = ratio * cos_i - cos_t * 8192;
                for (int k = 0; k < 3; k++)
                    o[k] = ratio * iv[k] * 16384 + coeff * nv[k];
                b.ox = round_sat(o[0], 27);
                b.oy = round_sat(o[1], 27);
                b.oz = round_sat(o[2], 27);
                return b;
            end
        end
        for (int k = 0; k < 3; k++)
            o[k] = iv[k] * (64'sd1 <<< 28) - 2 * dot * nv[k];
        b.ox = round_sat(o[0], 28);
        b.oy = round_sat(o[1], 28);
        b.oz = round_sat(o[2], 28);
        return b;
    endfunction

    // result checker
    always @(posedge aclk) begin
        bounce_t w, got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_took_transmission, m_total_internal,
                    m_out_dir_x, m_out_dir_y, m_out_dir_z};
            if (pending_bounces.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, got);
                errors++;
            end else begin
                w = pending_bounces.pop_front();
                checked++;
                if (got.tir) tir_seen++;
                if (got.trans) trans_seen++;
                if (got.trans !== w.trans)
                    $display("%0t: took_transmission exp %0d got %0d", $time, w.trans, got.trans);
                if (got.tir !== w.tir)
                    $display("%0t: total_internal exp %0d got %0d", $time, w.tir, got.tir);
                if (got.ox !== w.ox)
                    $display("%0t: out_dir_x exp %0d got %0d", $time, w.ox, got.ox);
                if (got.oy !== w.oy)
                    $display("%0t: out_dir_y exp %0d got %0d", $time, w.oy, got.oy);
                if (got.oz !== w.oz)
                    $display("%0t: out_dir_z exp %0d got %0d", $time, w.oz, got.oz);
                if (got !== w) errors++;
            end
        end
    end

    task automatic reg_write(logic [RegIdxW-1:0] idx, logic [DataW-1:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            RegIncident:    n_inc = val[IdxW-1:0];
            RegTransmitted: n_trn = val[IdxW-1:0];
            RegRatio:       n_rat = val[IdxW-1:0];
            default:        n_rsq = val[RsqW-1:0];
        endcase
        @(posedge aclk);
    endtask

    task automatic set_indices(int a, int b, int c, int d);
        reg_write(RegIncident, a);
        reg_write(RegTransmitted, b);
        reg_write(RegRatio, c);
        reg_write(RegRatioSq, d);
    endtask

    // present one item and hold it until accepted
    task automatic send_ray(ray_t r, logic typed, bounce_t want);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_in_dir_x <= r.ix; s_in_dir_y <= r.iy; s_in_dir_z <= r.iz;
        s_norm_x <= r.nx; s_norm_y <= r.ny; s_norm_z <= r.nz;
        s_uniform_rand <= r.u;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_bounces.push_back(typed ? want : scatter_ray(r));
        accepted++;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_bounces.size() != 0) @(posedge aclk);
        repeat (LatencyWait) @(posedge aclk);
    endtask

    function automatic logic signed [DirW-1:0] to_q14(real v);
        return DirW'($rtoi(v * 16384.0));
    endfunction

    // mostly unit vectors facing each other, the rest raw bits
    function automatic ray_t random_ray();
        ray_t r;
        real a[3], n[3], la, ln, d;
        logic [127:0] raw;
        if ($urandom_range(99) < 25) begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            r = raw[$bits(ray_t)-1:0];
        end else begin
            for (int k = 0; k < 3; k++) begin
                a[k] = $itor($urandom_range(2000)) - 1000.0;
                n[k] = $itor($urandom_range(2000)) - 1000.0;
            end
            la = $sqrt(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]);
            ln = $sqrt(n[0]*n[0] + n[1]*n[1] + n[2]*n[2]);
            if (la == 0.0) begin a[2] = -1.0; la = 1.0; end
            if (ln == 0.0) begin n[2] = 1.0; ln = 1.0; end
            d = a[0]*n[0] + a[1]*n[1] + a[2]*n[2];
            if (d > 0.0 && $urandom_range(99) < 85) la = -la;
            r.ix = to_q14(a[0] / la); r.iy = to_q14(a[1] / la);
            r.iz = to_q14(a[2] / la);
            r.nx = to_q14(n[0] / ln); r.ny = to_q14(n[1] / ln);
            r.nz = to_q14(n[2] / ln);
            r.u = RandW'($urandom);
        end
        return r;
    endfunction

    row_t directed[] = '{
        // head-on at matched indices: straight through
        '{'{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'h0000},
          1'b1, '{1'b1, 1'b0, 16'sd0, 16'sd0, -16'sd16384}},
        // zero vectors: grazing, total internal reflection
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h1234},
          1'b1, '{1'b0, 1'b1, 16'sd0, 16'sd0, 16'sd0}},
        // reversed normal: zero fresnel denominator forces reflection
        '{'{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, -16'sd16384, 16'hffff},
          1'b1, '{1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd16384}},
        '{'{-16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'hffff}, 1'b0, '0},
        '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
            16'hffff}, 1'b0, '0},
        '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
            -16'sd32768, 16'h0000}, 1'b0, '0},
        '{'{16'sd32767, -16'sd32768, 16'sd0, -16'sd32768, 16'sd32767, 16'sd32767,
            16'h8000}, 1'b0, '0},
        '{'{16'sd11585, 16'sd0, -16'sd11585, 16'sd0, 16'sd0, 16'sd16384, 16'h8000},
          1'b0, '0},
        '{'{16'sd16384, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd16384, 16'h0001},
          1'b0, '0},
        '{'{16'sd0, -16'sd11585, -16'sd11585, 16'sd0, 16'sd11585, 16'sd11585,
            16'h0000}, 1'b0, '0},
        '{'{16'sd9459, 16'sd9459, -16'sd9459, 16'sd0, 16'sd0, -16'sd16384, 16'h4000},
          1'b0, '0}
    };

    int settings[5][4] = '{
        '{8192, 8192, 8192, 16384},
        '{12288, 8192, 12288, 36864},
        '{8192, 12288, 5461, 7282},
        '{65535, 65535, 65535, 1048575},
        '{8192, 65535, 0, 0}
    };

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) set_indices(settings[ph][0], settings[ph][1],
                                    settings[ph][2], settings[ph][3]);
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 49; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 49; end
                default: begin send_idle = 18; recv_stall = 18; end
            endcase
            // directed rows at reset indices, then again under each setting
            foreach (directed[i])
                send_ray(directed[i].ray, directed[i].typed && ph == 0,
                         directed[i].want);
            for (int i = 0; i < ItemsPerPhase; i++)
                send_ray(random_ray(), 1'b0, '0);
            drain();
        end
        $display("covered %0d items over 5 index settings, %0d results checked",
                 accepted, checked);
        $display("refracted %0d, total internal reflection %0d", trans_seen, tir_seen);
        if (errors == 0 && pending_bounces.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
